// ===== hdl/mir_pkg.sv =====
package mir_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] HOST_INCREMENTAL = 8'h52;
  localparam logic [7:0] HOST_SELF_TEST   = 8'h54;
  localparam logic [7:0] HEADER_START     = 8'h80;
  localparam logic [7:0] HEADER_XSIGN     = 8'h10;
  localparam logic [7:0] HEADER_YSIGN     = 8'h08;
  localparam logic [7:0] SELF_TEST_BASE   = 8'ha0;
  localparam logic [7:0] SELF_TEST_SECOND = 8'h02;
  localparam logic [7:0] DELTA_LIMIT      = 8'd127;

  localparam logic CMD_UPDATE     = 1'b0;
  localparam logic CMD_HOST_WRITE = 1'b1;

  localparam logic [0:0] REG_REVISION = 1'b0;

  typedef enum logic [1:0] {
    BYTE_FIRST  = 2'd0,
    BYTE_SECOND = 2'd1,
    BYTE_THIRD  = 2'd2,
    BYTE_FOURTH = 2'd3
  } byte_idx_t;

  // one queued run of report bytes; the fourth byte is always zero
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       four;
  } job_t;

endpackage

// ===== hdl/mir_front.sv =====
module mir_front #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  input  logic [15:0]      goal_x,
  input  logic [15:0]      goal_y,
  input  logic [2:0]       goal_buttons,
  input  logic [7:0]       host_byte,
  input  logic [3:0]       revision,
  input  logic             q_full,
  output logic             q_push,
  output mir_pkg::job_t    q_job
);

  localparam int unsigned EW = ((POS_WIDTH > 16) ? POS_WIDTH : 16) + 1;

  logic [POS_WIDTH-1:0] pos_x;
  logic [POS_WIDTH-1:0] pos_y;
  logic [2:0]           buttons_seen;
  logic                 incremental_on;

  logic signed [EW-1:0] gx_e, gy_e, px_e, py_e, dx_full, dy_full;
  logic signed [7:0]    dx_c, dy_c;
  logic [7:0]           ax, ay, header;
  logic                 changed, accept, is_update, is_test;

  always_comb begin
    gx_e = {{(EW-16){goal_x[15]}}, goal_x};
    gy_e = {{(EW-16){goal_y[15]}}, goal_y};
    px_e = {{(EW-POS_WIDTH){pos_x[POS_WIDTH-1]}}, pos_x};
    py_e = {{(EW-POS_WIDTH){pos_y[POS_WIDTH-1]}}, pos_y};
    dx_full = gx_e - px_e;
    dy_full = gy_e - py_e;
    priority if (dx_full > $signed(EW'(mir_pkg::DELTA_LIMIT))) begin
      dx_c = $signed(mir_pkg::DELTA_LIMIT);
    end else if (dx_full < -$signed(EW'(mir_pkg::DELTA_LIMIT))) begin
      dx_c = -$signed(mir_pkg::DELTA_LIMIT);
    end else begin
      dx_c = dx_full[7:0];
    end
    priority if (dy_full > $signed(EW'(mir_pkg::DELTA_LIMIT))) begin
      dy_c = $signed(mir_pkg::DELTA_LIMIT);
    end else if (dy_full < -$signed(EW'(mir_pkg::DELTA_LIMIT))) begin
      dy_c = -$signed(mir_pkg::DELTA_LIMIT);
    end else begin
      dy_c = dy_full[7:0];
    end
    ax = dx_c[7] ? 8'(-dx_c) : 8'(dx_c);
    ay = dy_c[7] ? 8'(-dy_c) : 8'(dy_c);
    header = mir_pkg::HEADER_START | {5'd0, goal_buttons};
    if (!dx_c[7]) begin
      header = header | mir_pkg::HEADER_XSIGN;
    end
    if (dy_c[7]) begin
      header = header | mir_pkg::HEADER_YSIGN;
    end
    changed = (gx_e != px_e) || (gy_e != py_e) || (goal_buttons != buttons_seen);
    in_ready = !q_full;
    accept = in_valid && in_ready;
    is_update = (cmd == mir_pkg::CMD_UPDATE);
    is_test = (cmd == mir_pkg::CMD_HOST_WRITE) && (host_byte == mir_pkg::HOST_SELF_TEST);
    q_push = accept && ((is_update && changed && incremental_on) || is_test);
    if (is_update) begin
      q_job.b0 = header;
      q_job.b1 = ax;
      q_job.b2 = ay;
      q_job.four = 1'b0;
    end else begin
      q_job.b0 = mir_pkg::SELF_TEST_BASE | {4'd0, revision};
      q_job.b1 = mir_pkg::SELF_TEST_SECOND;
      q_job.b2 = 8'd0;
      q_job.four = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      buttons_seen <= '0;
      incremental_on <= 1'b0;
    end else if (accept) begin
      if (is_update && changed) begin
        pos_x <= pos_x + {{(POS_WIDTH-8){dx_c[7]}}, dx_c};
        pos_y <= pos_y + {{(POS_WIDTH-8){dy_c[7]}}, dy_c};
        buttons_seen <= goal_buttons;
      end
      if (!is_update && (host_byte == mir_pkg::HOST_INCREMENTAL)) begin
        incremental_on <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/mir_queue.sv =====
module mir_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mir_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mir_pkg::job_t head_job
);

  localparam int unsigned DEPTH = mir_pkg::QUEUE_DEPTH;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mir_pkg::job_t entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/mir_back.sv =====
module mir_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  mir_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    report_byte,
  output logic          last_of_run
);

  mir_pkg::byte_idx_t idx, idx_next;
  logic [7:0] sel_byte;
  logic       sel_last, load;

  always_comb begin
    unique case (idx)
      mir_pkg::BYTE_FIRST:  sel_byte = head_job.b0;
      mir_pkg::BYTE_SECOND: sel_byte = head_job.b1;
      mir_pkg::BYTE_THIRD:  sel_byte = head_job.b2;
      mir_pkg::BYTE_FOURTH: sel_byte = 8'd0;
      default:              sel_byte = 8'd0;
    endcase
    sel_last = head_job.four ? (idx == mir_pkg::BYTE_FOURTH) : (idx == mir_pkg::BYTE_THIRD);
    load = head_valid && (!out_valid || out_ready);
    pop = load && sel_last;
    idx_next = idx;
    if (load) begin
      idx_next = sel_last ? mir_pkg::BYTE_FIRST : mir_pkg::byte_idx_t'(idx + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= mir_pkg::BYTE_FIRST;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      report_byte <= sel_byte;
      last_of_run <= sel_last;
    end
  end

endmodule

// ===== hdl/mouse_incremental_reporter_top.sv =====
// serial mouse report generator
// input channel (in_valid/in_ready): cmd selects a pointer update (goal_x,
// goal_y, goal_buttons) or a host byte write (host_byte)
// output channel (out_valid/out_ready): one report_byte per transaction,
// last_of_run marks the final byte of an item's run
// an update that changes state in incremental mode gives three bytes, host
// byte 0x54 gives four self-test bytes, 0x52 enables incremental mode
// the input transaction writes a queue entry, and its first byte is then loaded into the output register
// throughput: one byte per cycle on the output while the receiver is ready
// and a run is queued; items with no bytes are taken every cycle while the queue is not full
// the front end queues runs in a two-entry queue; input stalls only when it
// is full, and a stalled receiver holds the output register
// apb register 0 (address 0): revision nibble, bits 3:0
// reset clears position, buttons, mode, revision and the queue
module mouse_incremental_reporter_top #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] goal_x,
  input  logic [15:0] goal_y,
  input  logic [2:0]  goal_buttons,
  input  logic [7:0]  host_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  report_byte,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]    revision;
  logic          q_full, q_push, q_pop, q_head_valid;
  mir_pkg::job_t q_job, q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mir_pkg::REG_REVISION) ? {28'd0, revision} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      revision <= '0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == mir_pkg::REG_REVISION)) begin
      revision <= pwdata[3:0];
    end
  end

  mir_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .goal_x         (goal_x),
    .goal_y         (goal_y),
    .goal_buttons   (goal_buttons),
    .host_byte      (host_byte),
    .revision       (revision),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_job)
  );

  mir_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  mir_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head_job    (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .report_byte (report_byte),
    .last_of_run (last_of_run)
  );

endmodule

// ===== hdl/mir_checker.sv =====
module mir_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  report_byte,
  input logic        last_of_run,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // held output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(report_byte) && $stable(last_of_run))
    else $error("output changed while stalled");

  // nothing presented right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // final byte is a magnitude or zero, never a header
  a_last_small: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> !report_byte[7])
    else $error("final byte has bit 7 set");

  // revision register reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && !paddr[2] |=>
      (paddr[2] || (prdata[3:0] == $past(pwdata[3:0]) && prdata[31:4] == 28'd0)))
    else $error("revision readback mismatch");

endmodule

bind mouse_incremental_reporter_top mir_checker u_mir_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .report_byte (report_byte),
  .last_of_run (last_of_run),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

// ===== tb/sv/tb_mouse_incremental_reporter_top.sv =====
module tb_mouse_incremental_reporter_top;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [2:0] REV_ADDR = 3'(4 * mir_pkg::REG_REVISION);

  typedef struct {
    logic               cmd;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic [2:0]         gb;
    logic [7:0]         hb;
  } mouse_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [15:0] goal_x = '0;
  logic [15:0] goal_y = '0;
  logic [2:0]  goal_buttons = '0;
  logic [7:0]  host_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  report_byte;
  logic        last_of_run;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mouse_incremental_reporter_top dut (.*);

  // predictor state
  logic signed [15:0] kept_x = '0;
  logic signed [15:0] kept_y = '0;
  logic [2:0]         kept_buttons = '0;
  logic               incremental_mode = 1'b0;
  logic [3:0]         revision = '0;

  mouse_item_t item_q[$];
  report_t     pending_reports[$];
  mouse_item_t on_bus;
  int          items_left = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          items_sent = 0;
  int          bytes_checked = 0;
  int          self_tests = 0;
  int          stall_cycles = 0;
  logic signed [15:0] aim_x = '0;
  logic signed [15:0] aim_y = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic predict_reports(input mouse_item_t it);
    int         dx;
    int         dy;
    int         lim;
    logic [7:0] hdr;
    lim = int'(mir_pkg::DELTA_LIMIT);
    if (it.cmd == mir_pkg::CMD_UPDATE) begin
      if (it.gx == kept_x && it.gy == kept_y && it.gb == kept_buttons) return;
      dx = int'(it.gx) - int'(kept_x);
      dy = int'(it.gy) - int'(kept_y);
      if (dx > lim) dx = lim;
      else if (dx < -lim) dx = -lim;
      if (dy > lim) dy = lim;
      else if (dy < -lim) dy = -lim;
      kept_x = kept_x + 16'(dx);
      kept_y = kept_y + 16'(dy);
      kept_buttons = it.gb;
      if (!incremental_mode) return;
      hdr = mir_pkg::HEADER_START | {5'b0, it.gb};
      if (dx >= 0) hdr = hdr | mir_pkg::HEADER_XSIGN;
      if (dy < 0) hdr = hdr | mir_pkg::HEADER_YSIGN;
      pending_reports.push_back('{hdr, 1'b0});
      pending_reports.push_back('{8'(dx < 0 ? -dx : dx), 1'b0});
      pending_reports.push_back('{8'(dy < 0 ? -dy : dy), 1'b1});
    end else if (it.hb == mir_pkg::HOST_INCREMENTAL) begin
      incremental_mode = 1'b1;
    end else if (it.hb == mir_pkg::HOST_SELF_TEST) begin
      self_tests++;
      pending_reports.push_back('{mir_pkg::SELF_TEST_BASE | {4'b0, revision}, 1'b0});
      pending_reports.push_back('{mir_pkg::SELF_TEST_SECOND, 1'b0});
      pending_reports.push_back('{8'h00, 1'b0});
      pending_reports.push_back('{8'h00, 1'b1});
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_reports(on_bus);
        items_left--;
        items_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (item_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_bus = item_q.pop_front();
          in_valid <= 1'b1;
          cmd <= on_bus.cmd;
          goal_x <= on_bus.gx;
          goal_y <= on_bus.gy;
          goal_buttons <= on_bus.gb;
          host_byte <= on_bus.hb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("unexpected report byte", report_byte, 8'h00);
        end else begin
          want = pending_reports.pop_front();
          bytes_checked++;
          if (report_byte !== want.data)
            report_mismatch("report_byte", report_byte, want.data);
          if (last_of_run !== want.last)
            report_mismatch("last_of_run", 8'(last_of_run), 8'(want.last));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d report bytes outstanding", pending_reports.size());
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic mouse_item_t make_update(input int x, input int y, input int b);
    mouse_item_t it;
    it.cmd = mir_pkg::CMD_UPDATE;
    it.gx = 16'(x);
    it.gy = 16'(y);
    it.gb = 3'(b);
    it.hb = 8'($urandom);
    return it;
  endfunction

  function automatic mouse_item_t make_host_write(input logic [7:0] b);
    mouse_item_t it;
    it.cmd = mir_pkg::CMD_HOST_WRITE;
    it.gx = 16'($urandom);
    it.gy = 16'($urandom);
    it.gb = 3'($urandom);
    it.hb = b;
    return it;
  endfunction

  function automatic mouse_item_t random_item();
    mouse_item_t it;
    int          sel;
    int          kind;
    sel = $urandom_range(99);
    if (sel < 70) begin
      it = make_update($urandom, $urandom, $urandom);
      kind = $urandom_range(9);
      if (kind <= 5) begin
        it.gx = aim_x + 16'($urandom_range(400) - 200);
        it.gy = aim_y + 16'($urandom_range(400) - 200);
        if (kind == 0) it.gb = kept_buttons;
      end else if (kind == 6) begin
        it.gx = aim_x;
        it.gy = aim_y;
      end
      aim_x = it.gx;
      aim_y = it.gy;
    end else begin
      sel = $urandom_range(99);
      if (sel < 50) it = make_host_write(mir_pkg::HOST_SELF_TEST);
      else if (sel < 60) it = make_host_write(mir_pkg::HOST_INCREMENTAL);
      else it = make_host_write(8'($urandom));
    end
    return it;
  endfunction

  task automatic queue_item(input mouse_item_t it);
    item_q.push_back(it);
    items_left++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (items_left != 0 || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_revision(input logic [3:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REV_ADDR;
    pwdata <= {28'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    revision = value;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[3:0] !== value)
      report_mismatch("revision readback", 8'(prdata[3:0]), 8'(value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int send_pct[3];
    int recv_pct[3];
    int revs[3];
    send_pct = '{26, 86, 0};
    recv_pct = '{86, 26, 0};
    revs = '{15, 0, $urandom_range(14, 1)};
    send_gap_pct = send_pct[0];
    recv_stall_pct = recv_pct[0];
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // mouse not initialized yet: state moves silently
    queue_item(make_update(5, -3, 1));
    queue_item(make_host_write(mir_pkg::HOST_SELF_TEST));
    queue_item(make_host_write(8'h00));
    queue_item(make_host_write(8'hff));
    queue_item(make_host_write(8'h53));
    queue_item(make_host_write(mir_pkg::HOST_INCREMENTAL));
    queue_item(make_update(5, -3, 1));
    queue_item(make_update(32767, -32768, 7));
    queue_item(make_update(32767, -32768, 7));
    queue_item(make_update(254, -100, 0));
    queue_item(make_update(254, -100, 5));
    queue_item(make_update(-32768, 32767, 2));
    queue_item(make_update(0, 0, 0));
    queue_item(make_update(100, -50, 3));
    queue_item(make_host_write(mir_pkg::HOST_SELF_TEST));
    queue_item(make_host_write(mir_pkg::HOST_INCREMENTAL));
    queue_item(make_update(-1, 1, 4));
    queue_item(make_update(-1, 1, 4));
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      send_gap_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      write_revision(4'(revs[p]));
      repeat (60) queue_item(random_item());
      wait_drained();
      repeat (60) queue_item(random_item());
      wait_drained();
    end

    $display("covered %0d input transactions, %0d report bytes checked, %0d self-tests",
             items_sent, bytes_checked, self_tests);
    $display("three pacing modes, revision set to 15, 0 and %0d", revs[2]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
